// File: rtl/assert_macros.svh
// Assertion macros for the triangular matrix product block.
// Users provide clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TMPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TMPS_ASSERT_NOW(lbl, ante, cons)
`define TMPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tmps_pkg.sv
// Shared types and constants for the triangular matrix product block.
// No dependencies.
package tmps_pkg;

  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_AB, ST_DR1, ST_CAB, ST_CAA, ST_DR2, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_AB, OP_CAB, OP_CAA
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } issue_t;

endpackage

// File: rtl/triangular_matrix_product_sum.sv
// Loads and reads: one transaction per cycle unless busy or a read is held by out_stall;
// read data is registered at the store read port, then in the output register.
// Compute runs through one multiply-accumulate pipeline fed by the stores, plus two pipeline drains.
// Synchronous active-low reset clears control and sets matrix_size to 32;
// store contents are undefined until written. Depends on tmps_pkg, tmps_seq, tmps_mac.
`include "assert_macros.svh"
module triangular_matrix_product_sum #(
  parameter int MAX_DIM = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [4:0]         out_row_res,
  output logic [4:0]         out_col_res,
  output logic signed [63:0] out_result_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int IDX_W = tmps_pkg::IDX_W;

  logic [5:0] size_r;
  logic [6:0] n;
  logic [IDX_W-1:0] nm1;
  logic [IDX_W-1:0] row_x, col_x;
  logic [AW-1:0] addr, raddr;
  logic acc, acc_read, start, in_store, in_size;
  logic busy, fin_fire, pipe_busy, out_free;
  tmps_pkg::issue_t iss;
  logic [63:0] c_rdata;

  logic rd_v_r, rd_in_r;
  logic [4:0] rd_row_r, rd_col_r;
  logic [AW-1:0] rd_addr_r;
  logic out_valid_r, out_kind_r;
  logic [4:0] out_row_r, out_col_r;
  logic [63:0] out_val_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (size_r == 6'd0) n = 7'd1;
    else if ({1'b0, size_r} > 7'(MAX_DIM)) n = 7'(MAX_DIM);
    else n = {1'b0, size_r};
  end
  assign nm1 = IDX_W'(n - 7'd1);

  assign row_x = IDX_W'(in_row);
  assign col_x = IDX_W'(in_col);
  assign addr = {row_x[IW-1:0], col_x[IW-1:0]};
  assign raddr = acc_read ? addr : rd_addr_r;
  assign in_store = ({2'b0, in_row} < 7'(MAX_DIM)) && ({2'b0, in_col} < 7'(MAX_DIM));
  assign in_size = ({2'b0, in_row} < n) && ({2'b0, in_col} < n);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy || (rd_v_r && !out_free);
  assign acc = in_valid && !in_stall;
  assign acc_read = acc && (in_mode == tmps_pkg::MODE_READ);
  assign start = acc && (in_mode == tmps_pkg::MODE_COMPUTE);

  tmps_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .nm1(nm1), .pipe_busy(pipe_busy),
    .out_free(out_free), .iss(iss), .busy(busy), .fin_fire(fin_fire)
  );

  tmps_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk(clk), .rst_n(rst_n), .iss(iss),
    .we_a(acc && in_store && (in_mode == tmps_pkg::MODE_LOAD_A)),
    .we_b(acc && in_store && (in_mode == tmps_pkg::MODE_LOAD_B)),
    .waddr(addr), .wdata(in_value), .raddr(raddr),
    .c_rdata(c_rdata), .pipe_busy(pipe_busy)
  );

  always_ff @(posedge clk) begin
    if (acc_read) begin
      rd_row_r <= in_row;
      rd_col_r <= in_col;
      rd_addr_r <= addr;
      rd_in_r <= in_size;
    end
    if (rd_v_r && out_free) begin
      out_kind_r <= tmps_pkg::KIND_READ;
      out_row_r <= rd_row_r;
      out_col_r <= rd_col_r;
      out_val_r <= rd_in_r ? c_rdata : 64'd0;
    end else if (fin_fire) begin
      out_kind_r <= tmps_pkg::KIND_DONE;
      out_row_r <= '0;
      out_col_r <= '0;
      out_val_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 6'd32;
      rd_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
      rd_v_r <= acc_read || (rd_v_r && !out_free);
      if ((rd_v_r && out_free) || fin_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_row_res = out_row_r;
  assign out_col_res = out_col_r;
  assign out_result_value = signed'(out_val_r);

  `TMPS_ASSERT_NOW(a_busy_stalls, busy, in_stall)
  `TMPS_ASSERT_NXT(a_fin_loads, fin_fire, out_valid_r && out_kind_r == tmps_pkg::KIND_DONE)
  `TMPS_ASSERT_NXT(a_rd_loads, rd_v_r && out_free, out_valid_r && out_kind_r == tmps_pkg::KIND_READ)
  `TMPS_ASSERT_NOW(a_no_mix, fin_fire, !rd_v_r)

endmodule

// File: rtl/tmps_seq.sv
// Compute sequencer: walks the i, j, k loops and issues one term per cycle.
// Depends on tmps_pkg.
module tmps_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tmps_pkg::IDX_W-1:0] nm1,
  input  logic                      pipe_busy,
  input  logic                      out_free,
  output tmps_pkg::issue_t          iss,
  output logic                      busy,
  output logic                      fin_fire
);

  tmps_pkg::state_t state_r, state_nxt;
  logic [tmps_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    case (state_r)
      tmps_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tmps_pkg::ST_AB;
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      tmps_pkg::ST_AB: begin
        if (k_r != nm1) begin
          k_nxt = k_r + 1'b1;
        end else if (j_r != nm1) begin
          j_nxt = j_r + 1'b1;
          k_nxt = i_r;
        end else if (i_r != nm1) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
          k_nxt = i_r + 1'b1;
        end else begin
          state_nxt = tmps_pkg::ST_DR1;
        end
      end
      tmps_pkg::ST_DR1: begin
        if (!pipe_busy) begin
          state_nxt = tmps_pkg::ST_CAB;
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      tmps_pkg::ST_CAB: begin
        if (k_r != nm1) begin
          k_nxt = k_r + 1'b1;
        end else begin
          k_nxt = '0;
          state_nxt = tmps_pkg::ST_CAA;
        end
      end
      tmps_pkg::ST_CAA: begin
        if (k_r != i_r) begin
          k_nxt = k_r + 1'b1;
        end else begin
          k_nxt = '0;
          state_nxt = tmps_pkg::ST_CAB;
          if (j_r != nm1) begin
            j_nxt = j_r + 1'b1;
          end else if (i_r != nm1) begin
            i_nxt = i_r + 1'b1;
            j_nxt = '0;
          end else begin
            state_nxt = tmps_pkg::ST_DR2;
          end
        end
      end
      tmps_pkg::ST_DR2: begin
        if (!pipe_busy) state_nxt = tmps_pkg::ST_FIN;
      end
      tmps_pkg::ST_FIN: begin
        if (out_free) state_nxt = tmps_pkg::ST_IDLE;
      end
      default: state_nxt = tmps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    iss.valid = 1'b0;
    iss.op = tmps_pkg::OP_AB;
    iss.first = 1'b0;
    iss.last = 1'b0;
    iss.i = i_r;
    iss.j = j_r;
    iss.k = k_r;
    fin_fire = 1'b0;
    case (state_r)
      tmps_pkg::ST_AB: begin
        iss.valid = 1'b1;
        iss.first = (k_r == i_r);
        iss.last = (k_r == nm1);
      end
      tmps_pkg::ST_CAB: begin
        iss.valid = 1'b1;
        iss.op = tmps_pkg::OP_CAB;
        iss.first = (k_r == '0);
      end
      tmps_pkg::ST_CAA: begin
        iss.valid = 1'b1;
        iss.op = tmps_pkg::OP_CAA;
        iss.last = (k_r == i_r);
      end
      tmps_pkg::ST_FIN: fin_fire = out_free;
      default: iss.valid = 1'b0;
    endcase
  end

  assign busy = (state_r != tmps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmps_pkg::ST_IDLE;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
    end
  end

endmodule

// File: rtl/tmps_mac.sv
// Matrix stores and multiply-accumulate pipeline (read, multiply, accumulate).
// Depends on tmps_pkg.
module tmps_mac #(
  parameter int MAX_DIM = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tmps_pkg::issue_t         iss,
  input  logic                     we_a,
  input  logic                     we_b,
  input  logic [2*$clog2(MAX_DIM)-1:0] waddr,
  input  logic [15:0]              wdata,
  input  logic [2*$clog2(MAX_DIM)-1:0] raddr,
  output logic [63:0]              c_rdata,
  output logic                     pipe_busy
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int DEPTH = 1 << AW;

  logic [15:0] a_mem [DEPTH];
  logic [15:0] b_mem [DEPTH];
  logic [39:0] ab_mem [DEPTH];
  logic [63:0] c_mem [DEPTH];

  logic [IW-1:0] ii, jj, kk;
  logic [AW-1:0] ra0, ra1, rb, rab, dst;
  logic [15:0] a_q0_r, a_q1_r, b_q_r;
  logic [39:0] ab_q_r;

  logic s1_v_r, s1_first_r, s1_last_r;
  tmps_pkg::op_t s1_op_r;
  logic [AW-1:0] s1_dst_r;
  logic s2_v_r, s2_first_r, s2_last_r;
  tmps_pkg::op_t s2_op_r;
  logic [AW-1:0] s2_dst_r;

  logic signed [39:0] mx;
  logic signed [15:0] my;
  logic signed [55:0] prod_r;
  logic [63:0] acc_r, sum;

  assign ii = iss.i[IW-1:0];
  assign jj = iss.j[IW-1:0];
  assign kk = iss.k[IW-1:0];
  assign ra0 = (iss.op == tmps_pkg::OP_CAA) ? {kk, ii} : {ii, kk};
  assign ra1 = {kk, jj};
  assign rb = (iss.op == tmps_pkg::OP_CAB) ? {jj, kk} : {kk, jj};
  assign rab = {ii, kk};
  assign dst = {ii, jj};

  always_ff @(posedge clk) begin
    if (we_a) a_mem[waddr] <= wdata;
    if (we_b) b_mem[waddr] <= wdata;
    a_q0_r <= a_mem[ra0];
    a_q1_r <= a_mem[ra1];
    b_q_r <= b_mem[rb];
    ab_q_r <= ab_mem[rab];
    c_rdata <= c_mem[raddr];
  end

  always_comb begin
    mx = 40'(signed'(a_q0_r));
    my = signed'(b_q_r);
    case (s1_op_r)
      tmps_pkg::OP_AB: ;
      tmps_pkg::OP_CAB: mx = signed'(ab_q_r);
      tmps_pkg::OP_CAA: my = signed'(a_q1_r);
      default: ;
    endcase
  end

  assign sum = (s2_first_r ? 64'd0 : acc_r) + 64'(prod_r);

  always_ff @(posedge clk) begin
    s1_op_r <= iss.op;
    s1_first_r <= iss.first;
    s1_last_r <= iss.last;
    s1_dst_r <= dst;
    prod_r <= mx * my;
    s2_op_r <= s1_op_r;
    s2_first_r <= s1_first_r;
    s2_last_r <= s1_last_r;
    s2_dst_r <= s1_dst_r;
    if (s2_v_r) begin
      acc_r <= sum;
      if (s2_last_r) begin
        if (s2_op_r == tmps_pkg::OP_AB) ab_mem[s2_dst_r] <= sum[39:0];
        else c_mem[s2_dst_r] <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss.valid;
      s2_v_r <= s1_v_r;
    end
  end

  assign pipe_busy = s1_v_r | s2_v_r;

endmodule
